### src/pfe_pkg.sv
// shared types, constants and square lookup functions for the playfair digraph encryptor
package pfe_pkg;

	localparam int LETTER_W    = 5;
	localparam int SQ_DIM      = 5;
	localparam int ROW_W       = SQ_DIM * LETTER_W;
	localparam int POS_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [LETTER_W-1:0]            letter_t;
	typedef logic [POS_W-1:0]               pos_t;
	typedef logic [ROW_W-1:0]               row_t;
	typedef logic [SQ_DIM-1:0][ROW_W-1:0]   square_t;
	typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

	// register indexes on the write port
	localparam cfg_idx_t REG_ROW0   = 3'd0;
	localparam cfg_idx_t REG_ROW4   = 3'd4;
	localparam cfg_idx_t REG_FILLER = 3'd5;

	localparam letter_t CODE_I = 5'd8;
	localparam letter_t CODE_J = 5'd9;
	localparam letter_t CODE_X = 5'd23;

	// a b c d e / f g h i k / l m n o p / q r s t u / v w x y z, row 0 lowest
	localparam square_t SQUARE_RESET = {
		25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
	};

	typedef enum logic [1:0] {
		JOB_PAIR   = 2'd0,
		JOB_PAD    = 2'd1,
		JOB_DOUBLE = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		letter_t   a;
		letter_t   b;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic found;
		pos_t row;
		pos_t col;
	} loc_t;

	function automatic letter_t cell_at(square_t sq, pos_t r, pos_t c);
		return sq[r][c*LETTER_W +: LETTER_W];
	endfunction

	function automatic pos_t wrap_inc(pos_t p);
		return (p == pos_t'(SQ_DIM - 1)) ? '0 : pos_t'(p + 1'b1);
	endfunction

	// first match in row-major order wins, so scan backwards
	function automatic loc_t locate(square_t sq, letter_t code);
		loc_t res;
		res = '0;
		for (int r = SQ_DIM - 1; r >= 0; r--) begin
			for (int c = SQ_DIM - 1; c >= 0; c--) begin
				if (sq[r][c*LETTER_W +: LETTER_W] == code) begin
					res.found = 1'b1;
					res.row   = pos_t'(r);
					res.col   = pos_t'(c);
				end
			end
		end
		return res;
	endfunction

endpackage

### src/pfe_front.sv
// front end: letter intake, j folding, pairing and job classification
module pfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pfe_pkg::letter_t plain_letter,
	input  logic             end_of_message,
	input  pfe_pkg::q_status_t q_status,
	output logic             push,
	output pfe_pkg::job_t    push_job
);
	import pfe_pkg::*;

	letter_t held_q;
	logic    held_valid_q;
	letter_t letter;
	logic    accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign letter   = (plain_letter == CODE_J) ? CODE_I : plain_letter;
	assign push     = accept && (held_valid_q || end_of_message);

	always_comb begin
		push_job.a = held_q;
		push_job.b = letter;
		if (held_valid_q) begin
			push_job.kind = (held_q == letter) ? JOB_DOUBLE : JOB_PAIR;
		end else begin
			push_job.kind = JOB_PAD;
			push_job.a    = letter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (held_valid_q) begin
				held_valid_q <= 1'b0;
			end else if (!end_of_message) begin
				held_q       <= letter;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

### src/pfe_queue.sv
// short job queue between front end and back end
module pfe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pfe_pkg::job_t      push_job,
	input  logic               pop,
	output pfe_pkg::job_t      head_job,
	output pfe_pkg::q_status_t q_status
);
	import pfe_pkg::*;

	job_t                entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head_job       = entries_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/pfe_back.sv
// back end: pair expansion, square lookup, substitution and letter output
module pfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pfe_pkg::square_t   square,
	input  pfe_pkg::letter_t   filler,
	input  pfe_pkg::job_t      head_job,
	input  pfe_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output pfe_pkg::letter_t   cipher_letter,
	output logic               last_of_run,
	output logic               not_found
);
	import pfe_pkg::*;

	// pair expansion
	logic    sub_q;
	letter_t pa, pb;
	logic    plast;
	logic    take;

	// lookup stage
	logic    v_s1;
	letter_t a_s1, b_s1;
	logic    last_s1;
	loc_t    la_s1, lb_s1;

	// output stage
	logic    v_s2;
	letter_t oa_s2, ob_s2;
	logic    nf_s2, last_s2;
	logic    half_q;

	logic    s1_ready, s2_ready, out_take;
	letter_t oa, ob;
	logic    nf;

	always_comb begin
		pa    = head_job.a;
		pb    = head_job.b;
		plast = 1'b1;
		unique case (head_job.kind)
			JOB_PAIR: begin
				pb = head_job.b;
			end
			JOB_PAD: begin
				pb = filler;
			end
			JOB_DOUBLE: begin
				if (!sub_q) begin
					pb    = filler;
					plast = 1'b0;
				end else begin
					pa = filler;
					pb = head_job.a;
				end
			end
			default: begin
				pb = head_job.b;
			end
		endcase
	end

	assign out_take = v_s2 && !out_stall;
	assign s2_ready = !v_s2 || (half_q && !out_stall);
	assign s1_ready = !v_s1 || s2_ready;
	assign take     = !q_status.empty && s1_ready;
	assign pop      = take && plast;

	always_comb begin
		oa = a_s1;
		ob = b_s1;
		nf = 1'b0;
		priority if (!(la_s1.found && lb_s1.found)) begin
			nf = 1'b1;
		end else if (la_s1.row == lb_s1.row) begin
			oa = cell_at(square, la_s1.row, wrap_inc(la_s1.col));
			ob = cell_at(square, lb_s1.row, wrap_inc(lb_s1.col));
		end else if (la_s1.col == lb_s1.col) begin
			oa = cell_at(square, wrap_inc(la_s1.row), la_s1.col);
			ob = cell_at(square, wrap_inc(lb_s1.row), lb_s1.col);
		end else begin
			oa = cell_at(square, la_s1.row, lb_s1.col);
			ob = cell_at(square, lb_s1.row, la_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_s1    <= pa;
			b_s1    <= pb;
			last_s1 <= plast;
			la_s1   <= locate(square, pa);
			lb_s1   <= locate(square, pb);
		end
		if (v_s1 && s2_ready) begin
			oa_s2   <= oa;
			ob_s2   <= ob;
			nf_s2   <= nf;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (take) begin
				sub_q <= (head_job.kind == JOB_DOUBLE) && !sub_q;
			end
			if (s1_ready) begin
				v_s1 <= take;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (out_take) begin
				half_q <= !half_q;
			end
		end
	end

	assign out_valid     = v_s2;
	assign cipher_letter = half_q ? ob_s2 : oa_s2;
	assign last_of_run   = half_q && last_s2;
	assign not_found     = nf_s2;

endmodule

### src/playfair_digraph_encrypt_top.sv
// top level of the playfair digraph encryptor: key square registers, front, queue, back
// path: a pair-completing item is written into the job queue, then the lookup and output stages
// throughput: one item per cycle into a four-job queue while it is not full; output one letter
// per cycle while out_stall is low; a pair gives two letters and a doubled pair four, all sent
// through the single output register; input stall rises only when the job queue is full
// reset: asynchronous, clears hold, queue and pipeline; square and filler return to defaults
module playfair_digraph_encrypt_top (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                wr_en,
	input  pfe_pkg::cfg_idx_t   wr_index,
	input  pfe_pkg::row_t       wr_data,
	// input item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  pfe_pkg::letter_t    plain_letter,
	input  logic                end_of_message,
	// result item channel
	output logic                out_valid,
	input  logic                out_stall,
	output pfe_pkg::letter_t    cipher_letter,
	output logic                last_of_run,
	output logic                not_found
);
	import pfe_pkg::*;

	// key square, row 0 in the low slot, column 0 in the low letter of each row
	square_t   square_q;
	letter_t   filler_q;

	// front to queue
	logic      push;
	job_t      push_job;
	// queue to back
	logic      pop;
	job_t      head_job;
	q_status_t q_status;

	// configuration registers; the user must write them only while the datapath is idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= SQUARE_RESET;
			filler_q <= CODE_X;
		end else if (wr_en) begin
			if (wr_index <= REG_ROW4) begin
				square_q[wr_index] <= wr_data;
			end else if (wr_index == REG_FILLER) begin
				filler_q <= wr_data[LETTER_W-1:0];
			end
		end
	end

	// front: folds j into i, holds the first letter of a pair, classifies jobs
	pfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.plain_letter   (plain_letter),
		.end_of_message (end_of_message),
		.q_status       (q_status),
		.push           (push),
		.push_job       (push_job)
	);

	// job queue decouples intake from the letter output rate
	pfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_status (q_status)
	);

	// back: splits doubled pairs, looks both letters up, substitutes, emits
	pfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.square        (square_q),
		.filler        (filler_q),
		.head_job      (head_job),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cipher_letter (cipher_letter),
		.last_of_run   (last_of_run),
		.not_found     (not_found)
	);

endmodule

### src/pfe_checker.sv
// port-level checker for the playfair digraph encryptor and its bind
module pfe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input pfe_pkg::letter_t  cipher_letter,
	input logic              last_of_run,
	input logic              not_found
);
	import pfe_pkg::*;

	// no result item while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result item offered during reset");

	// results come in pairs, so two taken items in a row never both close a run
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run)
		|=> !(out_valid && !out_stall && last_of_run))
		else $error("last_of_run on back-to-back result items");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(cipher_letter) && $stable(last_of_run) && $stable(not_found)))
		else $error("result payload changed while stalled");

endmodule

bind playfair_digraph_encrypt_top pfe_checker u_pfe_checker (.*);
